// ----- sv/homogeneous_point_transform_assert.svh -----
// Assertion macros used by the port-level checker file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/hpt_pkg.sv -----
// Types, constants and helpers of the homogeneous point transform.
package hpt_pkg;

	localparam int CoordWidth = 32;
	localparam int CoefWidth  = 16;
	localparam int ProdWidth  = CoordWidth + CoefWidth;
	localparam int AccWidth   = CoordWidth + 18;
	localparam int NumWidth   = AccWidth + 16;
	localparam int DivBits    = 2;
	localparam int DivStages  = (CoordWidth + DivBits - 1) / DivBits;
	localparam int PipeDepth  = 4 + DivStages + 1;

	localparam logic [1:0] RegRowZero  = 2'd0;
	localparam logic [1:0] RegRowOne   = 2'd1;
	localparam logic [1:0] RegRowTwo   = 2'd2;
	localparam logic [1:0] RegRowThree = 2'd3;

	localparam logic [63:0] RowZeroReset  = 64'h0000_0000_0000_1000;
	localparam logic [63:0] RowOneReset   = 64'h0000_0000_1000_0000;
	localparam logic [63:0] RowTwoReset   = 64'h0000_1000_0000_0000;
	localparam logic [63:0] RowThreeReset = 64'h1000_0000_0000_0000;

	localparam logic [AccWidth-1:0] WOne      = AccWidth'(1) << 28;
	localparam logic [AccWidth-1:0] HalfRange = AccWidth'(1) << (CoordWidth - 1);

	typedef struct packed {
		logic signed [CoordWidth-1:0] in_x;
		logic signed [CoordWidth-1:0] in_y;
		logic signed [CoordWidth-1:0] in_z;
	} in_point_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0] out_x;
		logic signed [CoordWidth-1:0] out_y;
		logic signed [CoordWidth-1:0] out_z;
		logic                         divided;
		logic                         saturated;
	} out_point_t;

	typedef struct packed {
		logic [AccWidth-1:0]   rem;
		logic [CoordWidth-1:0] nq;
		logic                  neg;
		logic                  ovf;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0]             lane;
		logic [AccWidth-1:0]         den;
		logic                        divide;
		logic [2:0][CoordWidth-1:0]  plain;
		logic                        plain_sat;
	} div_item_t;

	// Returns {clamped, value} for a sign and magnitude pair.
	function automatic logic [CoordWidth:0] clamp_coord(input logic neg,
			input logic [AccWidth-1:0] mag);
		logic [AccWidth-1:0] limit;
		logic [AccWidth-1:0] m;
		logic                sat;
		limit = neg ? HalfRange : HalfRange - AccWidth'(1);
		m     = mag;
		sat   = 1'b0;
		if (mag > limit) begin
			m   = limit;
			sat = 1'b1;
		end
		return {sat, neg ? (-m[CoordWidth-1:0]) : m[CoordWidth-1:0]};
	endfunction

endpackage

// ----- sv/hpt_div_stage.sv -----
// One divider pipeline stage: a few restoring quotient steps on three lanes.
module hpt_div_stage import hpt_pkg::*; #(
	parameter int STEPS = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  div_item_t up_data,
	output logic      dn_valid,
	input  logic      dn_ready,
	output div_item_t dn_data
);

	logic      v_q;
	div_item_t d_q;
	div_item_t nxt;

	assign up_ready = !v_q || dn_ready;
	assign dn_valid = v_q;
	assign dn_data  = d_q;

	always_comb begin
		logic [AccWidth:0] r2;
		logic              qbit;
		nxt = up_data;
		for (int l = 0; l < 3; l++) begin
			for (int s = 0; s < STEPS; s++) begin
				r2 = {nxt.lane[l].rem, nxt.lane[l].nq[CoordWidth-1]};
				if (r2 >= {1'b0, nxt.den}) begin
					r2   = r2 - {1'b0, nxt.den};
					qbit = 1'b1;
				end else begin
					qbit = 1'b0;
				end
				nxt.lane[l].rem = r2[AccWidth-1:0];
				nxt.lane[l].nq  = {nxt.lane[l].nq[CoordWidth-2:0], qbit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q <= nxt;
		end
	end

endmodule

// ----- sv/homogeneous_point_transform.sv -----
// Top level: 4x4 homogeneous point transform with perspective divide.
// Takes one point per cycle while the output side is not stalled and returns one result per
// point, in order, through one stage of multipliers, one of row sums, one of magnitudes, one
// of overflow check and setup, sixteen divider stages that each produce two quotient bits for
// x, y and z in parallel, and the output register. Every stage holds its item under
// backpressure, so bubbles close up and a waiting result does not block new input.
module homogeneous_point_transform import hpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_point_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_point_t  out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] row_q [4];

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [ProdWidth-1:0] prod_s1 [4][3];
	logic signed [CoefWidth-1:0] c3_s1 [4];
	logic signed [AccWidth-1:0]  acc_s2 [4];
	logic [AccWidth-1:0]         mag_s3 [4];
	logic                        sign_s3 [4];
	logic                        divide_s3;
	div_item_t                   item_s4;
	div_item_t                   item_d;

	logic                        dv [DivStages+1];
	logic                        dr [DivStages+1];
	div_item_t                   dd [DivStages+1];

	logic                        out_valid_q;
	out_point_t                  out_q;
	out_point_t                  out_d;
	logic signed [CoordWidth-1:0] pt [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= RowZeroReset;
			row_q[1] <= RowOneReset;
			row_q[2] <= RowTwoReset;
			row_q[3] <= RowThreeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRowZero:  row_q[0] <= cfg_wdata;
				RegRowOne:   row_q[1] <= cfg_wdata;
				RegRowTwo:   row_q[2] <= cfg_wdata;
				RegRowThree: row_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rdy_s4   = !v_s4 || dr[0];
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign pt[0] = in_data.in_x;
	assign pt[1] = in_data.in_y;
	assign pt[2] = in_data.in_z;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(row_q[r][CoefWidth*c +: CoefWidth]) * pt[c];
				end
				c3_s1[r] <= $signed(row_q[r][CoefWidth*3 +: CoefWidth]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int r = 0; r < 4; r++) begin
				acc_s2[r] <= AccWidth'(prod_s1[r][0]) + AccWidth'(prod_s1[r][1])
					+ AccWidth'(prod_s1[r][2]) + (AccWidth'(c3_s1[r]) <<< 16);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			for (int r = 0; r < 4; r++) begin
				sign_s3[r] <= acc_s2[r][AccWidth-1];
				mag_s3[r]  <= acc_s2[r][AccWidth-1] ? AccWidth'(-acc_s2[r])
					: AccWidth'(acc_s2[r]);
			end
			divide_s3 <= !((acc_s2[3] == '0) || (acc_s2[3] == $signed(WOne)));
		end
	end

	always_comb begin
		logic [NumWidth-1:0]            num;
		logic [AccWidth+CoordWidth-1:0] num_ext;
		logic [AccWidth+CoordWidth-1:0] den_sh;
		logic [CoordWidth:0]            pc;
		item_d           = '0;
		item_d.den       = mag_s3[3];
		item_d.divide    = divide_s3;
		item_d.plain_sat = 1'b0;
		den_sh           = {mag_s3[3], {CoordWidth{1'b0}}};
		for (int l = 0; l < 3; l++) begin
			num     = {mag_s3[l], 16'b0};
			num_ext = (AccWidth+CoordWidth)'(num);
			item_d.lane[l].ovf = num_ext >= den_sh;
			item_d.lane[l].rem = AccWidth'(num >> CoordWidth);
			item_d.lane[l].nq  = num[CoordWidth-1:0];
			item_d.lane[l].neg = sign_s3[l] ^ sign_s3[3];
			pc = clamp_coord(sign_s3[l], mag_s3[l] >> 12);
			item_d.plain[l]  = pc[CoordWidth-1:0];
			item_d.plain_sat = item_d.plain_sat | pc[CoordWidth];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			item_s4 <= item_d;
		end
	end

	assign dv[0] = v_s4;
	assign dd[0] = item_s4;

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		localparam int Steps = (CoordWidth - k*DivBits < DivBits)
			? (CoordWidth - k*DivBits) : DivBits;
		hpt_div_stage #(
			.STEPS(Steps)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(dv[k]),
			.up_ready(dr[k]),
			.up_data (dd[k]),
			.dn_valid(dv[k+1]),
			.dn_ready(dr[k+1]),
			.dn_data (dd[k+1])
		);
	end

	assign dr[DivStages] = !out_valid_q || out_ready;

	always_comb begin
		logic [CoordWidth:0]          qc;
		logic [2:0][CoordWidth-1:0]   val;
		logic                         sat;
		sat = 1'b0;
		val = '0;
		for (int l = 0; l < 3; l++) begin
			qc = clamp_coord(dd[DivStages].lane[l].neg,
				AccWidth'(dd[DivStages].lane[l].nq));
			if (dd[DivStages].lane[l].ovf) begin
				qc = {1'b1, dd[DivStages].lane[l].neg ? HalfRange[CoordWidth-1:0]
					: (HalfRange[CoordWidth-1:0] - CoordWidth'(1))};
			end
			val[l] = qc[CoordWidth-1:0];
			sat    = sat | qc[CoordWidth];
		end
		if (dd[DivStages].divide) begin
			out_d.out_x     = val[0];
			out_d.out_y     = val[1];
			out_d.out_z     = val[2];
			out_d.saturated = sat;
		end else begin
			out_d.out_x     = dd[DivStages].plain[0];
			out_d.out_y     = dd[DivStages].plain[1];
			out_d.out_z     = dd[DivStages].plain[2];
			out_d.saturated = dd[DivStages].plain_sat;
		end
		out_d.divided = dd[DivStages].divide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dr[DivStages]) begin
			out_valid_q <= dv[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (dr[DivStages] && dv[DivStages]) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- sv/hpt_checker.sv -----
// Port-level checks of the homogeneous point transform, bound to the top level.
`include "homogeneous_point_transform_assert.svh"

module hpt_checker import hpt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input in_point_t   in_data,
	input logic        out_valid,
	input logic        out_ready,
	input out_point_t  out_data,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [63:0] cfg_wdata
);

	localparam int CntWidth = $clog2(PipeDepth + 1);

	logic [CntWidth-1:0] inflight_q;
	logic                in_xfer;
	logic                out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CntWidth'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CntWidth'(1);
		end
	end

	`HPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")
	`HPT_ASSERT_NOW(a_full_stall, !in_ready, out_valid && !out_ready, "input blocked without output backpressure")
	`HPT_ASSERT_NOW(a_no_phantom, out_valid, inflight_q != '0, "result with no point in flight")
	`HPT_ASSERT_NOW(a_depth, 1'b1, inflight_q <= CntWidth'(PipeDepth), "more points in flight than stages")

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

// ----- sim/point_transform_checker.sv -----
// Checker for the homogeneous point transform: predicts each result and compares it.
module point_transform_checker import hpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_point_t   in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_point_t  out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	output int          errors,
	output int          pending
);

	logic [63:0] matrix_rows [4];
	out_point_t  expected_points [$];

	function automatic out_point_t transform_point(in_point_t p);
		logic signed [CoordWidth-1:0] coord [3];
		logic signed [15:0]           coef;
		longint                       sums [4];
		logic [127:0]                 wmag;
		logic [127:0]                 amag;
		logic [127:0]                 quot;
		logic [127:0]                 limit;
		logic                         wneg;
		logic                         neg;
		logic                         divide;
		logic [CoordWidth-1:0]        res [3];
		out_point_t                   r;
		coord[0] = p.in_x;
		coord[1] = p.in_y;
		coord[2] = p.in_z;
		r = '0;
		for (int row = 0; row < 4; row++) begin
			sums[row] = 0;
			for (int c = 0; c < 3; c++) begin
				coef = matrix_rows[row][16*c +: 16];
				sums[row] += longint'(coef) * longint'(coord[c]);
			end
			coef = matrix_rows[row][48 +: 16];
			sums[row] += longint'(coef) * 65536;
		end
		divide = !(sums[3] == 0 || sums[3] == (longint'(1) << 28));
		wneg = sums[3] < 0;
		wmag = wneg ? 128'(-sums[3]) : 128'(sums[3]);
		for (int i = 0; i < 3; i++) begin
			amag = sums[i] < 0 ? 128'(-sums[i]) : 128'(sums[i]);
			if (divide) begin
				quot = (amag << 16) / wmag;
				neg  = (sums[i] < 0) != wneg;
			end else begin
				quot = amag >> 12;
				neg  = sums[i] < 0;
			end
			limit = neg ? (128'(1) << 31) : (128'(1) << 31) - 1;
			if (quot > limit) begin
				quot = limit;
				r.saturated = 1'b1;
			end
			res[i] = neg ? -quot[CoordWidth-1:0] : quot[CoordWidth-1:0];
		end
		r.out_x   = res[0];
		r.out_y   = res[1];
		r.out_z   = res[2];
		r.divided = divide;
		return r;
	endfunction

	assign pending = expected_points.size();

	always @(posedge clk or negedge arst_n) begin
		out_point_t want;
		if (!arst_n) begin
			matrix_rows[RegRowZero]  <= RowZeroReset;
			matrix_rows[RegRowOne]   <= RowOneReset;
			matrix_rows[RegRowTwo]   <= RowTwoReset;
			matrix_rows[RegRowThree] <= RowThreeReset;
			expected_points.delete();
			errors <= 0;
		end else begin
			if (cfg_we)
				matrix_rows[cfg_index] <= cfg_wdata;
			if (in_valid && in_ready)
				expected_points.push_back(transform_point(in_data));
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transfer: %h", out_data);
					errors <= errors + 1;
				end else begin
					want = expected_points.pop_front();
					if (out_data !== want) begin
						if (errors < 10)
							$display("mismatch: x %h/%h y %h/%h z %h/%h div %b/%b sat %b/%b",
								want.out_x, out_data.out_x, want.out_y, out_data.out_y,
								want.out_z, out_data.out_z, want.divided, out_data.divided,
								want.saturated, out_data.saturated);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the homogeneous point transform: stimulus, matrix setup and verdict.
module tb;
	import hpt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_point_t   in_data;
	logic        out_valid;
	logic        out_ready;
	out_point_t  out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_stall_pct;

	homogeneous_point_transform dut (.*);

	point_transform_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("** homogeneous_point_transform: FAILED **");
		$finish;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			3: return 32'($signed($urandom_range(4194304)) - 2097152);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(6))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h1000;
			3: return 16'h0000;
			4: return 16'($signed($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_row(logic [1:0] idx, logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
			logic [63:0] r3);
		drain();
		write_row(RegRowZero, r0);
		write_row(RegRowOne, r1);
		write_row(RegRowTwo, r2);
		write_row(RegRowThree, r3);
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{in_x: x, in_y: y, in_z: z};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		logic [63:0] w_row;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_index      = RegRowZero;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_point(32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff);

		load_matrix(64'h7fff_8000_7fff_8000, 64'h8000_8000_8000_8000,
			64'h7fff_7fff_7fff_7fff, 64'h0000_0000_0000_0000);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
			64'h0000_1000_0000_0000, 64'h1000_0000_0000_1000);
		send_point(32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
		send_point(32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
		send_point(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000);
		send_point(32'hfff0_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
		send_point(32'hf000_0000, 32'h0000_0001, 32'h0000_0000);

		load_matrix(64'hffff_ffff_ffff_ffff, 64'h7fff_7fff_7fff_7fff,
			64'h8000_8000_8000_8000, 64'h0000_0000_0000_0001);
		send_point(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
			recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
			for (int set = 0; set < 4; set++) begin
				w_row = {16'h1000 + 16'($signed($urandom_range(256)) - 128),
					16'($signed($urandom_range(64)) - 32),
					16'($signed($urandom_range(64)) - 32),
					16'($signed($urandom_range(64)) - 32)};
				if (set == 3)
					w_row = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
				load_matrix({pick_coef(), pick_coef(), pick_coef(), pick_coef()},
					{pick_coef(), pick_coef(), pick_coef(), pick_coef()},
					{pick_coef(), pick_coef(), pick_coef(), pick_coef()}, w_row);
				for (int n = 0; n < 108; n++) begin
					if (n == 54) begin
						in_valid <= 1'b0;
						wait (pending == 0);
						@(negedge clk);
					end
					send_point(pick_coord(), pick_coord(), pick_coord());
				end
			end
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** homogeneous_point_transform: PASSED **");
		else
			$display("** homogeneous_point_transform: FAILED **");
		$finish;
	end

endmodule
